>>> design/iss_pkg.sv
// ----------------------------------------------------------------------------
// Irrigation sector sequencer package
// Shared constants, register codes and item types of the sequencer.
// ----------------------------------------------------------------------------
package iss_pkg;

   localparam int SECTORS     = 8;
   localparam int LEVEL_BITS  = 8;
   localparam int IDX_BITS    = 4;
   localparam int BYTE_BITS   = 8;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 64;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ENABLE      = 3'd0,
      CSR_TANK_START  = 3'd1,
      CSR_TANK_EMPTY  = 3'd2,
      CSR_TARGETS     = 3'd3,
      CSR_MAX_SECONDS = 3'd4,
      CSR_PUMP_MODE   = 3'd5,
      CSR_SECTORS     = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      PUMP_PRESSURE   = 2'd0,
      PUMP_FILL       = 2'd1,
      PUMP_FILL_SOLAR = 2'd2
   } pump_mode_type;

   localparam logic        ENABLE_RESET      = 1'b0;
   localparam logic [7:0]  TANK_START_RESET  = 8'd25;
   localparam logic [7:0]  TANK_EMPTY_RESET  = 8'd5;
   localparam logic [63:0] TARGETS_RESET     = 64'h5050_5050_5050_5050;
   localparam logic [15:0] MAX_SECONDS_RESET = 16'd300;
   localparam logic [1:0]  PUMP_MODE_RESET   = 2'd0;
   localparam logic [IDX_BITS-1:0] SECTORS_RESET = 4'd8;

   typedef struct packed {
      logic eligible;
      logic keep;
   } lane_flags_type;

   typedef struct packed {
      logic [7:0]          valve_mask;
      logic                pump_on;
      logic [IDX_BITS-1:0] active_sector;
      logic                timer_load;
      logic                schedule_rearm;
   } rsp_payload_type;

endpackage

>>> design/iss_if.sv
// ----------------------------------------------------------------------------
// Irrigation sector sequencer channels
// Valid/ready channels for event items, result items and register writes.
// ----------------------------------------------------------------------------
interface iss_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic        timer_done;
   logic        power_ok;
   logic        solar_ok;
   logic        tank_valid;
   logic [7:0]  tank_level;
   logic [7:0]  moisture_valid;
   logic [63:0] moisture_levels;

   modport source (output valid, cmd, timer_done, power_ok, solar_ok, tank_valid,
                   tank_level, moisture_valid, moisture_levels, input ready);
   modport sink (input valid, cmd, timer_done, power_ok, solar_ok, tank_valid,
                 tank_level, moisture_valid, moisture_levels, output ready);
endinterface

interface iss_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] valve_mask;
   logic       pump_on;
   logic [3:0] active_sector;
   logic       timer_load;
   logic       schedule_rearm;

   modport source (output valid, valve_mask, pump_on, active_sector, timer_load,
                   schedule_rearm, input ready);
   modport sink (input valid, valve_mask, pump_on, active_sector, timer_load,
                 schedule_rearm, output ready);
endinterface

interface iss_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> design/iss_lane.sv
// ----------------------------------------------------------------------------
// Sector lane
// Compares one sector's moisture reading with its target.
// ----------------------------------------------------------------------------
module iss_lane (
   input  logic [iss_pkg::LEVEL_BITS-1:0] level,
   input  logic [iss_pkg::LEVEL_BITS-1:0] target,
   input  logic                           reading_valid,
   output iss_pkg::lane_flags_type        flags
);
   import iss_pkg::*;

   logic below;

   assign below          = level < target;
   assign flags.eligible = reading_valid & below;
   assign flags.keep     = ~reading_valid | below;

endmodule

>>> design/iss_merge.sv
// ----------------------------------------------------------------------------
// Lane merge
// Finds the first eligible sector at or above a start index and below the
// sector count, and selects the keep flag of the active sector.
// ----------------------------------------------------------------------------
module iss_merge (
   input  iss_pkg::lane_flags_type         flags [iss_pkg::SECTORS],
   input  logic [iss_pkg::IDX_BITS-1:0]    from_idx,
   input  logic [iss_pkg::IDX_BITS-1:0]    count,
   input  logic [iss_pkg::IDX_BITS-1:0]    active,
   output logic [iss_pkg::IDX_BITS-1:0]    found,
   output logic                            keep
);
   import iss_pkg::*;

   always_comb begin
      found = count;
      keep  = 1'b0;
      for (int k = SECTORS - 1; k >= 0; k--) begin
         if (flags[k].eligible && (IDX_BITS'(k) >= from_idx) && (IDX_BITS'(k) < count)) begin
            found = IDX_BITS'(k);
         end
      end
      for (int k = 0; k < SECTORS; k++) begin
         if (active == IDX_BITS'(k)) begin
            keep = flags[k].keep;
         end
      end
   end

endmodule

>>> design/irrigation_sector_sequencer.sv
// ----------------------------------------------------------------------------
// Irrigation sector sequencer
// The result item of an accepted event item is registered before it appears.
// Throughput: one item per cycle while results are taken; all sector lanes
// compare in parallel; the merge stage's priority encoder is combinational.
// A two-entry output buffer keeps input ready registered against output stalls.
// Reset restores register defaults and idles the sequence; no clearing pass.
// ----------------------------------------------------------------------------
module irrigation_sector_sequencer (
   input logic       clock,
   input logic       reset,
   iss_req_if.sink   req_ch,
   iss_rsp_if.source rsp_ch,
   iss_csr_if.sink   csr_ch
);
   import iss_pkg::*;

   logic                enable_ff;
   logic [7:0]          tank_start_ff;
   logic [7:0]          tank_empty_ff;
   logic [63:0]         targets_ff;
   logic [15:0]         max_seconds_ff;
   logic [1:0]          pump_mode_ff;
   logic [IDX_BITS-1:0] sectors_ff;
   logic [IDX_BITS-1:0] active_ff;
   logic [IDX_BITS-1:0] active_in;

   logic                out_valid_ff;
   logic                out_valid_in;
   rsp_payload_type     out_data_ff;
   rsp_payload_type     out_data_in;
   logic                skid_valid_ff;
   logic                skid_valid_in;
   rsp_payload_type     skid_data_ff;
   logic                req_ready_ff;

   logic                accept;
   logic                take;
   logic                csr_write;
   logic [IDX_BITS-1:0] count;
   logic [IDX_BITS-1:0] csr_count;
   logic [IDX_BITS-1:0] cur;
   logic [IDX_BITS-1:0] from_idx;
   logic [IDX_BITS-1:0] found;
   logic                keep;
   logic                tank_ok;
   logic                can_start;
   logic                blocked;
   logic                running;
   logic                load;
   logic                rearm;
   logic                pump;
   rsp_payload_type     result;
   lane_flags_type      flags [SECTORS];

   assign accept    = req_ch.valid & req_ready_ff;
   assign take      = out_valid_ff & rsp_ch.ready;
   assign csr_write = csr_ch.valid & csr_ch.ready;

   assign req_ch.ready = req_ready_ff;
   assign csr_ch.ready = 1'b1;

   assign count     = (sectors_ff > IDX_BITS'(SECTORS)) ? IDX_BITS'(SECTORS) : sectors_ff;
   assign csr_count = (csr_ch.data[IDX_BITS-1:0] > IDX_BITS'(SECTORS)) ?
                      IDX_BITS'(SECTORS) : csr_ch.data[IDX_BITS-1:0];
   assign cur       = (active_ff > count) ? count : active_ff;
   assign from_idx  = (cur < count) ? cur + IDX_BITS'(1) : '0;

   for (genvar k = 0; k < SECTORS; k++) begin : g_lane
      iss_lane u_lane (
         .level         (req_ch.moisture_levels[BYTE_BITS*k +: LEVEL_BITS]),
         .target        (targets_ff[BYTE_BITS*k +: LEVEL_BITS]),
         .reading_valid (req_ch.moisture_valid[k]),
         .flags         (flags[k])
      );
   end

   iss_merge u_merge (
      .flags    (flags),
      .from_idx (from_idx),
      .count    (count),
      .active   (cur),
      .found    (found),
      .keep     (keep)
   );

   assign tank_ok   = ~req_ch.tank_valid | (req_ch.tank_level > tank_empty_ff);
   assign can_start = ~req_ch.tank_valid | (req_ch.tank_level >= tank_start_ff);
   assign blocked   = ~enable_ff | ~req_ch.power_ok | ~tank_ok;

   always_comb begin
      active_in = cur;
      load      = 1'b0;
      rearm     = 1'b0;
      if (req_ch.cmd) begin
         if ((cur < count) && blocked) begin
            active_in = count;
         end
      end else begin
         if (cur < count) begin
            if (req_ch.timer_done || blocked || !keep) begin
               active_in = blocked ? count : found;
            end
            load = (active_in < count) && (active_in != cur);
         end else if (req_ch.timer_done && !blocked && can_start) begin
            active_in = found;
            load      = found < count;
         end
         rearm = active_in >= count;
      end
   end

   assign running = active_in < count;

   always_comb begin
      unique case (pump_mode_ff)
         PUMP_PRESSURE:   pump = running & tank_ok;
         PUMP_FILL:       pump = req_ch.tank_valid & ~can_start;
         PUMP_FILL_SOLAR: pump = req_ch.tank_valid & ~can_start & req_ch.solar_ok;
         default:         pump = 1'b0;
      endcase
   end

   always_comb begin
      for (int b = 0; b < 8; b++) begin
         result.valve_mask[b] = running && (active_in == IDX_BITS'(b));
      end
      result.pump_on        = pump;
      result.active_sector  = running ? active_in + IDX_BITS'(1) : '0;
      result.timer_load     = load;
      result.schedule_rearm = rearm;
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept;
            out_data_in  = result;
         end
      end else if (accept) begin
         if (out_valid_ff) begin
            skid_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= ENABLE_RESET;
         tank_start_ff  <= TANK_START_RESET;
         tank_empty_ff  <= TANK_EMPTY_RESET;
         targets_ff     <= TARGETS_RESET;
         max_seconds_ff <= MAX_SECONDS_RESET;
         pump_mode_ff   <= PUMP_MODE_RESET;
         sectors_ff     <= SECTORS_RESET;
         active_ff      <= (SECTORS_RESET > IDX_BITS'(SECTORS)) ?
                           IDX_BITS'(SECTORS) : SECTORS_RESET;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
         req_ready_ff   <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         req_ready_ff  <= ~skid_valid_in;
         if (accept) begin
            active_ff <= active_in;
         end else if (csr_write && (csr_ch.index == CSR_SECTORS) && (active_ff > csr_count)) begin
            active_ff <= csr_count;
         end
         if (csr_write) begin
            unique case (csr_ch.index)
               CSR_ENABLE:      enable_ff      <= csr_ch.data[0];
               CSR_TANK_START:  tank_start_ff  <= csr_ch.data[7:0];
               CSR_TANK_EMPTY:  tank_empty_ff  <= csr_ch.data[7:0];
               CSR_TARGETS:     targets_ff     <= csr_ch.data;
               CSR_MAX_SECONDS: max_seconds_ff <= csr_ch.data[15:0];
               CSR_PUMP_MODE:   pump_mode_ff   <= csr_ch.data[1:0];
               CSR_SECTORS:     sectors_ff     <= csr_ch.data[IDX_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      if (accept && !take && out_valid_ff) begin
         skid_data_ff <= result;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.valve_mask     = out_data_ff.valve_mask;
   assign rsp_ch.pump_on        = out_data_ff.pump_on;
   assign rsp_ch.active_sector  = out_data_ff.active_sector;
   assign rsp_ch.timer_load     = out_data_ff.timer_load;
   assign rsp_ch.schedule_rearm = out_data_ff.schedule_rearm;

endmodule

>>> design/iss_checker.sv
// ----------------------------------------------------------------------------
// Irrigation sector sequencer checker
// Port-level properties of result items, bound to the top level.
// ----------------------------------------------------------------------------
module iss_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] valve_mask,
   input logic       pump_on,
   input logic [3:0] active_sector,
   input logic       timer_load,
   input logic       schedule_rearm
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Result item dropped while stalled.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(valve_mask) && $stable(active_sector)
                                  && $stable(pump_on) && $stable(timer_load)
                                  && $stable(schedule_rearm))
      else $error("Result item changed while stalled.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(valve_mask) && ((active_sector == 4'd0) == (valve_mask == 8'd0)))
      else $error("Valve mask disagrees with the active sector.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && timer_load |-> (active_sector != 4'd0) && !schedule_rearm)
      else $error("Timer load without an open sector.");

endmodule

bind irrigation_sector_sequencer iss_checker u_iss_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .valve_mask     (rsp_ch.valve_mask),
   .pump_on        (rsp_ch.pump_on),
   .active_sector  (rsp_ch.active_sector),
   .timer_load     (rsp_ch.timer_load),
   .schedule_rearm (rsp_ch.schedule_rearm)
);

>>> verif/irrigation_sector_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Irrigation sector sequencer testbench
// Drives periodic passes and interlock events through the request channel and
// checks each result item against a cycle-free watering-order model or drill row.
// A short drill walks the sector search, timeouts, interlocks and a shrinking
// sector count, then randomized phases run under several register settings.
// ----------------------------------------------------------------------------
module irrigation_sector_sequencer_tb;
   import iss_pkg::*;

   localparam int NUM_PHASES = 12;
   localparam int ITEMS_PER_PHASE = 108;
   localparam int PRESSURE_PHASE = 3;
   localparam int HOLD_CYCLES = 80;
   localparam int BURST_ITEMS = 40;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [1:0] PUMP_UNDEFINED = 2'd3;

   typedef enum logic {
      CMD_PERIODIC  = 1'b0,
      CMD_INTERLOCK = 1'b1
   } cmd_code_type;

   typedef struct packed {
      cmd_code_type cmd;
      logic         timer_done;
      logic         power_ok;
      logic         solar_ok;
      logic         tank_valid;
      logic [7:0]   tank_level;
      logic [7:0]   moisture_valid;
      logic [63:0]  moisture_levels;
   } pass_item_type;

   typedef struct packed {
      pass_item_type   item;
      logic            typed;
      rsp_payload_type want;
   } drill_step_type;

   typedef struct packed {
      logic                enable;
      logic [7:0]          tank_start;
      logic [7:0]          tank_empty;
      logic [63:0]         targets;
      logic [15:0]         max_seconds;
      logic [1:0]          pump;
      logic [IDX_BITS-1:0] sectors;
   } settings_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   iss_req_if req_bus ();
   iss_rsp_if rsp_bus ();
   iss_csr_if csr_bus ();

   irrigation_sector_sequencer i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow copy of the registers and the active sector.
   logic                shadow_enable = ENABLE_RESET;
   logic [7:0]          shadow_tank_start = TANK_START_RESET;
   logic [7:0]          shadow_tank_empty = TANK_EMPTY_RESET;
   logic [63:0]         shadow_targets = TARGETS_RESET;
   logic [15:0]         shadow_max_seconds = MAX_SECONDS_RESET;
   logic [1:0]          shadow_pump = PUMP_MODE_RESET;
   logic [IDX_BITS-1:0] shadow_sectors = SECTORS_RESET;
   logic [IDX_BITS-1:0] shadow_index = 4'(SECTORS);

   rsp_payload_type due_outputs[$];
   drill_step_type  drill_plan[$];

   bit sender_idle = 1'b1;
   bit receiver_idle = 1'b1;
   bit hold_request = 1'b0;
   int burst_left = 0;
   int cycle_count = 0;
   int mismatches = 0;
   int items_sent = 0;
   int results_checked = 0;
   int starts_due = 0;
   int rearms_due = 0;
   int input_stalls = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (req_bus.valid && !req_bus.ready && !reset)
         input_stalls <= input_stalls + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped at the cycle limit with %0d results outstanding.",
                  due_outputs.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [IDX_BITS-1:0] fitted_count();
      return (shadow_sectors > SECTORS) ? IDX_BITS'(SECTORS) : shadow_sectors;
   endfunction

   function automatic bit dry_at(pass_item_type it, int k);
      return it.moisture_levels[k*BYTE_BITS +: LEVEL_BITS]
             < shadow_targets[k*BYTE_BITS +: LEVEL_BITS];
   endfunction

   function automatic logic [IDX_BITS-1:0] first_dry(pass_item_type it, int from,
                                                     logic [IDX_BITS-1:0] n);
      for (int k = from; k < n; k++)
         if (it.moisture_valid[k] && dry_at(it, k))
            return IDX_BITS'(k);
      return n;
   endfunction

   function automatic void note_register(csr_index_type idx, logic [63:0] data);
      case (idx)
         CSR_ENABLE:      shadow_enable = data[0];
         CSR_TANK_START:  shadow_tank_start = data[7:0];
         CSR_TANK_EMPTY:  shadow_tank_empty = data[7:0];
         CSR_TARGETS:     shadow_targets = data;
         CSR_MAX_SECONDS: shadow_max_seconds = data[15:0];
         CSR_PUMP_MODE:   shadow_pump = data[1:0];
         CSR_SECTORS: begin
            shadow_sectors = data[IDX_BITS-1:0];
            if (shadow_index > fitted_count())
               shadow_index = fitted_count();
         end
         default: ;
      endcase
   endfunction

   function automatic rsp_payload_type predict_outputs(pass_item_type it);
      rsp_payload_type     r;
      logic [IDX_BITS-1:0] n;
      logic [IDX_BITS-1:0] k;
      logic                tank_ok;
      logic                can_start;
      logic                blocked;
      logic                keep;
      logic                running;
      n = fitted_count();
      tank_ok = !it.tank_valid || (it.tank_level > shadow_tank_empty);
      can_start = !it.tank_valid || (it.tank_level >= shadow_tank_start);
      blocked = !shadow_enable || !it.power_ok || !tank_ok;
      r = '0;
      if (shadow_index > n)
         shadow_index = n;
      if (it.cmd == CMD_INTERLOCK) begin
         if (shadow_index < n && blocked)
            shadow_index = n;
      end else begin
         if (shadow_index < n) begin
            k = shadow_index;
            keep = !it.moisture_valid[k[2:0]] || dry_at(it, int'(k));
            if (it.timer_done || blocked || !keep)
               shadow_index = blocked ? n : first_dry(it, int'(k) + 1, n);
            if (shadow_index < n && shadow_index != k)
               r.timer_load = 1'b1;
         end else if (it.timer_done && !blocked && can_start) begin
            shadow_index = first_dry(it, 0, n);
            if (shadow_index < n)
               r.timer_load = 1'b1;
         end
         if (shadow_index >= n)
            r.schedule_rearm = 1'b1;
      end
      running = shadow_index < n;
      case (shadow_pump)
         PUMP_PRESSURE:   r.pump_on = running && tank_ok;
         PUMP_FILL:       r.pump_on = it.tank_valid && !can_start;
         PUMP_FILL_SOLAR: r.pump_on = it.tank_valid && !can_start && it.solar_ok;
         default:         r.pump_on = 1'b0;
      endcase
      if (running) begin
         r.valve_mask = 8'd1 << shadow_index[2:0];
         r.active_sector = shadow_index + 4'd1;
      end
      return r;
   endfunction

   function automatic void drill_row(cmd_code_type cmd, logic expired, logic power,
                                     logic solar, logic tvalid, logic [7:0] tank,
                                     logic [7:0] mvalid, logic [63:0] levels,
                                     logic typed = 1'b0, logic [7:0] valve = 8'h00,
                                     logic pump = 1'b0, logic [3:0] sector = 4'd0,
                                     logic load = 1'b0, logic rearm = 1'b0);
      drill_step_type s;
      s.item.cmd = cmd;
      s.item.timer_done = expired;
      s.item.power_ok = power;
      s.item.solar_ok = solar;
      s.item.tank_valid = tvalid;
      s.item.tank_level = tank;
      s.item.moisture_valid = mvalid;
      s.item.moisture_levels = levels;
      s.typed = typed;
      s.want.valve_mask = valve;
      s.want.pump_on = pump;
      s.want.active_sector = sector;
      s.want.timer_load = load;
      s.want.schedule_rearm = rearm;
      drill_plan.insert(drill_plan.size(), s);
   endfunction

   function automatic pass_item_type random_item();
      pass_item_type it;
      logic [7:0] tgt;
      it.cmd = cmd_code_type'($urandom_range(0, 1));
      it.timer_done = 1'($urandom);
      it.power_ok = 1'($urandom);
      it.solar_ok = 1'($urandom);
      it.tank_valid = 1'($urandom);
      it.tank_level = 8'($urandom);
      it.moisture_valid = 8'($urandom);
      it.moisture_levels = {$urandom, $urandom};
      if ($urandom_range(0, 3) != 0) begin
         it.cmd = ($urandom_range(0, 9) == 0) ? CMD_INTERLOCK : CMD_PERIODIC;
         it.timer_done = ($urandom_range(0, 2) == 0);
         it.power_ok = ($urandom_range(0, 19) != 0);
         it.tank_valid = ($urandom_range(0, 5) != 0);
         case ($urandom_range(0, 5))
            0: it.tank_level = shadow_tank_empty;
            1: it.tank_level = shadow_tank_empty + 8'd1;
            2: it.tank_level = shadow_tank_start - 8'd1;
            3: it.tank_level = shadow_tank_start;
            default: ;
         endcase
         it.moisture_valid = 8'($urandom | $urandom);
         for (int k = 0; k < SECTORS; k++) begin
            tgt = shadow_targets[k*BYTE_BITS +: BYTE_BITS];
            case ($urandom_range(0, 3))
               0: it.moisture_levels[k*BYTE_BITS +: BYTE_BITS] = tgt;
               1: it.moisture_levels[k*BYTE_BITS +: BYTE_BITS] = tgt - 8'd1;
               2: it.moisture_levels[k*BYTE_BITS +: BYTE_BITS] =
                     tgt + 8'($urandom_range(1, 20));
               default: ;
            endcase
         end
      end
      return it;
   endfunction

   function automatic settings_type random_settings();
      settings_type s;
      s.enable = ($urandom_range(0, 7) != 0);
      s.tank_start = 8'($urandom);
      s.tank_empty = 8'($urandom_range(0, 60));
      s.targets = {$urandom, $urandom};
      s.max_seconds = 16'($urandom);
      s.pump = 2'($urandom_range(0, 3));
      s.sectors = IDX_BITS'($urandom_range(0, SECTORS));
      return s;
   endfunction

   task automatic write_reg(csr_index_type idx, logic [63:0] data);
      @(negedge clock);
      csr_bus.index = idx;
      csr_bus.data = data;
      csr_bus.valid = 1'b1;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
      note_register(idx, data);
   endtask

   task automatic apply_settings(settings_type s);
      write_reg(CSR_ENABLE, 64'(s.enable));
      write_reg(CSR_TANK_START, 64'(s.tank_start));
      write_reg(CSR_TANK_EMPTY, 64'(s.tank_empty));
      write_reg(CSR_TARGETS, s.targets);
      write_reg(CSR_MAX_SECONDS, 64'(s.max_seconds));
      write_reg(CSR_PUMP_MODE, 64'(s.pump));
      write_reg(CSR_SECTORS, 64'(s.sectors));
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic send_item(pass_item_type it, logic typed, rsp_payload_type want);
      rsp_payload_type predicted;
      int gap;
      @(negedge clock);
      if (burst_left > 0) begin
         gap = 0;
         burst_left--;
      end else begin
         gap = sender_idle ? $urandom_range(0, 12) : 0;
      end
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.cmd = it.cmd;
      req_bus.timer_done = it.timer_done;
      req_bus.power_ok = it.power_ok;
      req_bus.solar_ok = it.solar_ok;
      req_bus.tank_valid = it.tank_valid;
      req_bus.tank_level = it.tank_level;
      req_bus.moisture_valid = it.moisture_valid;
      req_bus.moisture_levels = it.moisture_levels;
      req_bus.valid = 1'b1;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      predicted = predict_outputs(it);
      if (typed)
         predicted = want;
      due_outputs.insert(due_outputs.size(), predicted);
      items_sent++;
      starts_due += predicted.timer_load;
      rearms_due += predicted.schedule_rearm;
   endtask

   task automatic settle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (due_outputs.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_drill(int lo, int hi);
      for (int i = lo; i < hi; i++)
         send_item(drill_plan[i].item, drill_plan[i].typed, drill_plan[i].want);
      settle();
   endtask

   initial begin : output_checker
      rsp_payload_type got;
      rsp_payload_type want;
      int gap;
      rsp_bus.ready = 1'b0;
      while (reset !== 1'b0)
         @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_bus.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         gap = receiver_idle ? $urandom_range(0, 12) : 0;
         if (gap > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid)
            @(posedge clock);
         got.valve_mask = rsp_bus.valve_mask;
         got.pump_on = rsp_bus.pump_on;
         got.active_sector = rsp_bus.active_sector;
         got.timer_load = rsp_bus.timer_load;
         got.schedule_rearm = rsp_bus.schedule_rearm;
         results_checked++;
         if (due_outputs.size() == 0) begin
            $error("result item arrived with nothing expected");
            mismatches++;
         end else begin
            want = due_outputs.pop_front();
            if (got.valve_mask !== want.valve_mask) begin
               $error("valve_mask: expected %h, got %h", want.valve_mask, got.valve_mask);
               mismatches++;
            end
            if (got.pump_on !== want.pump_on) begin
               $error("pump_on: expected %h, got %h", want.pump_on, got.pump_on);
               mismatches++;
            end
            if (got.active_sector !== want.active_sector) begin
               $error("active_sector: expected %h, got %h", want.active_sector,
                      got.active_sector);
               mismatches++;
            end
            if (got.timer_load !== want.timer_load) begin
               $error("timer_load: expected %h, got %h", want.timer_load, got.timer_load);
               mismatches++;
            end
            if (got.schedule_rearm !== want.schedule_rearm) begin
               $error("schedule_rearm: expected %h, got %h", want.schedule_rearm,
                      got.schedule_rearm);
               mismatches++;
            end
         end
      end
   end

   initial begin : stimulus
      settings_type cfg;
      int split_reset;
      int split_main;
      req_bus.valid = 1'b0;
      req_bus.cmd = CMD_PERIODIC;
      req_bus.timer_done = 1'b0;
      req_bus.power_ok = 1'b0;
      req_bus.solar_ok = 1'b0;
      req_bus.tank_valid = 1'b0;
      req_bus.tank_level = 8'h00;
      req_bus.moisture_valid = 8'h00;
      req_bus.moisture_levels = 64'h0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_ENABLE;
      csr_bus.data = 64'h0;

      // Out of reset watering is disabled.
      drill_row(CMD_PERIODIC, 1, 1, 0, 1, 8'd200, 8'hFF, 64'h0,
                1, 8'h00, 0, 4'd0, 0, 1);
      drill_row(CMD_INTERLOCK, 0, 1, 1, 1, 8'd10, 8'hFF, 64'h0,
                1, 8'h00, 0, 4'd0, 0, 0);
      split_reset = drill_plan.size();
      drill_row(CMD_PERIODIC, 1, 1, 0, 1, 8'd255, 8'hFF, 64'hFFFF_FFFF_FFFF_FF00,
                1, 8'h01, 1, 4'd1, 1, 0);
      drill_row(CMD_PERIODIC, 0, 1, 0, 1, 8'd255, 8'hFF, 64'hFFFF_FFFF_FFFF_FF00);
      drill_row(CMD_PERIODIC, 0, 1, 0, 1, 8'd255, 8'hFE, 64'hFFFF_FFFF_FFFF_FF50);
      drill_row(CMD_PERIODIC, 0, 1, 0, 1, 8'd255, 8'hFF, 64'h00FF_FFFF_00FF_FF50);
      drill_row(CMD_PERIODIC, 1, 1, 0, 1, 8'd255, 8'hFF, 64'h00FF_FFFF_00FF_FF50);
      drill_row(CMD_PERIODIC, 1, 1, 0, 1, 8'd255, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF,
                1, 8'h00, 0, 4'd0, 0, 1);
      drill_row(CMD_PERIODIC, 1, 1, 0, 1, 8'd24, 8'hFF, 64'h0,
                1, 8'h00, 0, 4'd0, 0, 1);
      // A missing tank reading never blocks a start.
      drill_row(CMD_PERIODIC, 1, 1, 0, 0, 8'd0, 8'hFF, 64'h0,
                1, 8'h01, 1, 4'd1, 1, 0);
      drill_row(CMD_INTERLOCK, 0, 1, 0, 1, 8'd255, 8'hFF, 64'h0);
      drill_row(CMD_INTERLOCK, 0, 1, 0, 1, 8'd5, 8'hFF, 64'h0,
                1, 8'h00, 0, 4'd0, 0, 0);
      drill_row(CMD_PERIODIC, 1, 0, 0, 1, 8'd255, 8'hFF, 64'h0,
                1, 8'h00, 0, 4'd0, 0, 1);
      drill_row(CMD_PERIODIC, 1, 1, 0, 1, 8'd255, 8'hFF, 64'h0,
                1, 8'h01, 1, 4'd1, 1, 0);
      drill_row(CMD_INTERLOCK, 0, 0, 0, 1, 8'd255, 8'hFF, 64'h0,
                1, 8'h00, 0, 4'd0, 0, 0);
      drill_row(CMD_PERIODIC, 1, 1, 1, 1, 8'd255, 8'hFF, 64'h0);
      drill_row(CMD_PERIODIC, 0, 0, 0, 1, 8'd255, 8'hFF, 64'h0,
                1, 8'h00, 0, 4'd0, 0, 1);
      drill_row(CMD_PERIODIC, 1, 1, 0, 1, 8'd255, 8'h00, 64'h0,
                1, 8'h00, 0, 4'd0, 0, 1);
      drill_row(CMD_PERIODIC, 1, 1, 0, 1, 8'd255, 8'hFF, 64'h00FF_FFFF_FFFF_FFFF,
                1, 8'h80, 1, 4'd8, 1, 0);
      split_main = drill_plan.size();
      drill_row(CMD_PERIODIC, 0, 1, 0, 1, 8'd255, 8'hFF, 64'h0);
      drill_row(CMD_PERIODIC, 1, 1, 0, 1, 8'd255, 8'hFF, 64'hFF00_00FF_FFFF_FFFF);
      drill_row(CMD_PERIODIC, 1, 1, 0, 1, 8'd255, 8'hFF, 64'hFFFF_FFFF_00FF_FFFF);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_drill(0, split_reset);
      cfg.enable = 1'b1;
      cfg.tank_start = TANK_START_RESET;
      cfg.tank_empty = TANK_EMPTY_RESET;
      cfg.targets = TARGETS_RESET;
      cfg.max_seconds = MAX_SECONDS_RESET;
      cfg.pump = PUMP_PRESSURE;
      cfg.sectors = IDX_BITS'(SECTORS);
      apply_settings(cfg);
      run_drill(split_reset, split_main);
      // Shrinking the sector count under the open top sector closes it.
      write_reg(CSR_SECTORS, 64'd4);
      @(negedge clock);
      csr_bus.valid = 1'b0;
      run_drill(split_main, drill_plan.size());

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         cfg = random_settings();
         case (phase)
            0: begin
               cfg.enable = 1'b1;
               cfg.pump = PUMP_PRESSURE;
               cfg.sectors = IDX_BITS'(SECTORS);
            end
            1: begin
               cfg.enable = 1'b1;
               cfg.tank_start = 8'hFF;
               cfg.tank_empty = 8'hFF;
               cfg.targets = '1;
               cfg.max_seconds = 16'hFFFF;
               cfg.pump = PUMP_FILL_SOLAR;
               cfg.sectors = IDX_BITS'(SECTORS);
            end
            2: begin
               cfg.enable = 1'b1;
               cfg.tank_start = 8'h00;
               cfg.tank_empty = 8'h00;
               cfg.targets = '0;
               cfg.max_seconds = 16'h0000;
               cfg.pump = PUMP_UNDEFINED;
               cfg.sectors = '0;
            end
            PRESSURE_PHASE: begin
               cfg.enable = 1'b1;
               cfg.sectors = IDX_BITS'(SECTORS);
            end
            4: begin
               cfg.enable = 1'b0;
               cfg.pump = PUMP_FILL;
            end
            5: begin
               cfg.enable = 1'b1;
               cfg.sectors = '1;
            end
            default: ;
         endcase
         apply_settings(cfg);
         sender_idle = (phase % 3 != 1);
         receiver_idle = (phase % 4 != 2);
         if (phase == PRESSURE_PHASE) begin
            hold_request = 1'b1;
            burst_left = BURST_ITEMS;
         end
         repeat (ITEMS_PER_PHASE)
            send_item(random_item(), 1'b0, '0);
         settle();
      end

      repeat (8) @(posedge clock);
      $display("Sent %0d event items under %0d register settings; %0d sector starts and",
               items_sent, NUM_PHASES + 3, starts_due);
      $display("%0d rearm results among %0d checked; input held back on %0d cycles.",
               rearms_due, results_checked, input_stalls);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
